// ===== sv/int64_divide_unit_top_assert.svh =====
// Assertion macros for the 64-bit divide unit.
// Depends on nothing; included by the top level only.
`ifndef INT64_DIVIDE_UNIT_TOP_ASSERT_SVH
`define INT64_DIVIDE_UNIT_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I64DIV_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I64DIV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/i64div_pkg.sv =====
// Shared types and constants for the 64-bit divide unit.
// Depends on nothing; used by i64div_core, int64_divide_unit_top and the testbench.
package i64div_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned Steps     = 64;

   typedef logic [DataWidth-1:0] word_type;

   typedef struct packed {
      word_type rem;
      word_type nq;
      word_type dvsr;
      logic     a_neg;
      logic     q_neg;
      logic     dz;
   } work_type;

endpackage

// ===== sv/i64div_core.sv =====
// Pipeline of single-bit restoring division steps, one step per register stage.
// Depends on i64div_pkg for the work item type and the data width.
module i64div_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  i64div_pkg::work_type in_work,
   output logic                out_valid,
   input  logic                out_ready,
   output i64div_pkg::work_type out_work
);

   function automatic i64div_pkg::work_type div_step(input i64div_pkg::work_type w);
      i64div_pkg::work_type            res;
      logic [i64div_pkg::DataWidth:0] shifted;
      logic [i64div_pkg::DataWidth:0] diff;
      logic                           take;
      res     = w;
      shifted = {w.rem, w.nq[i64div_pkg::DataWidth-1]};
      diff    = shifted - {1'b0, w.dvsr};
      take    = !diff[i64div_pkg::DataWidth];
      res.rem = take ? diff[i64div_pkg::DataWidth-1:0] : shifted[i64div_pkg::DataWidth-1:0];
      res.nq  = {w.nq[i64div_pkg::DataWidth-2:0], take};
      return res;
   endfunction

   i64div_pkg::work_type         stage_ff [i64div_pkg::Steps];
   i64div_pkg::work_type         stage_in [i64div_pkg::Steps];
   logic [i64div_pkg::Steps-1:0] valid_ff;
   logic [i64div_pkg::Steps-1:0] prev_valid;
   logic [i64div_pkg::Steps:0]   ready;

   always_comb begin
      ready[i64div_pkg::Steps] = out_ready;
      for (int g = i64div_pkg::Steps - 1; g >= 0; g--) begin
         ready[g] = !valid_ff[g] || ready[g+1];
      end
   end

   always_comb begin
      prev_valid[0] = in_valid;
      stage_in[0]   = div_step(in_work);
      for (int g = 1; g < i64div_pkg::Steps; g++) begin
         prev_valid[g] = valid_ff[g-1];
         stage_in[g]   = div_step(stage_ff[g-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int g = 0; g < i64div_pkg::Steps; g++) begin
            if (ready[g]) begin
               valid_ff[g] <= prev_valid[g];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < i64div_pkg::Steps; g++) begin
         if (ready[g] && prev_valid[g]) begin
            stage_ff[g] <= stage_in[g];
         end
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[i64div_pkg::Steps-1];
   assign out_work  = stage_ff[i64div_pkg::Steps-1];

endmodule

// ===== sv/int64_divide_unit_top.sv =====
// Top level of the 64-bit divide unit: operand stage, step pipeline, result stage.
// Depends on i64div_pkg, i64div_core and int64_divide_unit_top_assert.svh.

// This unit divides 64-bit operands, unsigned or signed, and accepts one request
// in every cycle while req_stall is low. The accepting edge loads the operand
// magnitudes, the step pipeline resolves one quotient bit per stage with one 65-bit
// subtract, and the output register restores the signs of the results. Stalls on
// the result side back up only as far as there are full stages, so the unit keeps
// accepting requests into any empty stage. A zero divisor returns zero quotient and
// remainder with the divide_by_zero flag set.
`include "int64_divide_unit_top_assert.svh"

module int64_divide_unit_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_dividend,
   input  logic [63:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_quotient,
   output logic [63:0] rsp_remainder,
   output logic        rsp_divide_by_zero
);

   logic                 pre_valid_ff;
   i64div_pkg::work_type pre_ff;
   i64div_pkg::work_type pre_in;
   logic                 pre_ready;
   logic                 a_neg;
   logic                 b_neg;

   logic                 core_in_ready;
   logic                 core_out_valid;
   logic                 core_out_ready;
   i64div_pkg::work_type core_out_work;

   logic                 rsp_valid_ff;
   i64div_pkg::word_type rsp_quotient_ff;
   i64div_pkg::word_type rsp_quotient_in;
   i64div_pkg::word_type rsp_remainder_ff;
   i64div_pkg::word_type rsp_remainder_in;
   logic                 rsp_divide_by_zero_ff;

   assign a_neg        = req_opcode && req_dividend[i64div_pkg::DataWidth-1];
   assign b_neg        = req_opcode && req_divisor[i64div_pkg::DataWidth-1];

   always_comb begin
      pre_in.rem   = '0;
      pre_in.nq    = a_neg ? (i64div_pkg::word_type'(0) - req_dividend) : req_dividend;
      pre_in.dvsr  = b_neg ? (i64div_pkg::word_type'(0) - req_divisor) : req_divisor;
      pre_in.a_neg = a_neg;
      pre_in.q_neg = a_neg ^ b_neg;
      pre_in.dz    = (req_divisor == '0);
   end

   assign pre_ready = !pre_valid_ff || core_in_ready;
   assign req_stall = !pre_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (pre_ready) begin
         pre_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pre_ready && req_valid) begin
         pre_ff <= pre_in;
      end
   end

   i64div_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pre_valid_ff),
      .in_ready  (core_in_ready),
      .in_work   (pre_ff),
      .out_valid (core_out_valid),
      .out_ready (core_out_ready),
      .out_work  (core_out_work)
   );

   always_comb begin
      if (core_out_work.dz) begin
         rsp_quotient_in  = '0;
         rsp_remainder_in = '0;
      end else begin
         rsp_quotient_in  = core_out_work.q_neg
                          ? (i64div_pkg::word_type'(0) - core_out_work.nq) : core_out_work.nq;
         rsp_remainder_in = core_out_work.a_neg
                          ? (i64div_pkg::word_type'(0) - core_out_work.rem) : core_out_work.rem;
      end
   end

   assign core_out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_out_ready) begin
         rsp_valid_ff <= core_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (core_out_ready && core_out_valid) begin
         rsp_quotient_ff       <= rsp_quotient_in;
         rsp_remainder_ff      <= rsp_remainder_in;
         rsp_divide_by_zero_ff <= core_out_work.dz;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_quotient_ff;
   assign rsp_remainder      = rsp_remainder_ff;
   assign rsp_divide_by_zero = rsp_divide_by_zero_ff;

   `I64DIV_ASSERT_IMPLIES(a_rem_below_divisor, clock, reset,
      core_out_valid && !core_out_work.dz, core_out_work.rem < core_out_work.dvsr,
      "Remainder magnitude is not below the divisor magnitude.")
   `I64DIV_ASSERT_IMPLIES(a_zero_divisor_result, clock, reset,
      rsp_valid_ff && rsp_divide_by_zero_ff,
      rsp_quotient_ff == '0 && rsp_remainder_ff == '0,
      "A zero divisor produced a nonzero result.")
   `I64DIV_ASSERT_NEXT(a_result_captured, clock, reset,
      core_out_valid && core_out_ready, rsp_valid_ff,
      "A finished division was not captured in the output register.")

endmodule

// ===== test/int64_divide_unit_checker.sv =====
// Checker for the 64-bit divide unit: a shared opcode/result package and a module that
// watches both channels, predicts every accepted request and compares the results.
// Depends on i64div_pkg for the word type and data width.
package i64div_tb_pkg;

   import i64div_pkg::*;

   typedef enum logic {
      OP_UNSIGNED = 1'b0,
      OP_SIGNED   = 1'b1
   } div_opcode_e;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     divide_by_zero;
   } division_t;

endpackage

module int64_divide_unit_checker
   import i64div_pkg::*;
   import i64div_tb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_opcode,
   input  logic [63:0] req_dividend,
   input  logic [63:0] req_divisor,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_quotient,
   input  logic [63:0] rsp_remainder,
   input  logic        rsp_divide_by_zero,
   output int          mismatch_count,
   output int          divisions_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   division_t divisions_in_flight[$];

   initial mismatch_count = 0;

   assign divisions_pending = divisions_in_flight.size();

   task automatic report_mismatch(string what);
      $display("%0t ns: MISMATCH %s", $time, what);
      mismatch_count++;
   endtask

   // Restoring division of magnitudes, one quotient bit per step, with the sign fix-up
   // applied afterwards in signed mode.
   function automatic division_t divide_words(div_opcode_e op, word_type dividend,
                                              word_type divisor);
      division_t expected;
      word_type  num;
      word_type  den;
      word_type  q;
      word_type  r;
      logic      dividend_neg;
      logic      divisor_neg;
      logic      carry;
      expected = '0;
      if (divisor == '0) begin
         expected.divide_by_zero = 1'b1;
         return expected;
      end
      dividend_neg = (op == OP_SIGNED) && dividend[DataWidth-1];
      divisor_neg  = (op == OP_SIGNED) && divisor[DataWidth-1];
      num = dividend_neg ? -dividend : dividend;
      den = divisor_neg ? -divisor : divisor;
      q = '0;
      r = '0;
      for (int i = DataWidth - 1; i >= 0; i--) begin
         carry = r[DataWidth-1];
         r = {r[DataWidth-2:0], num[i]};
         if (carry || r >= den) begin
            r = r - den;
            q[i] = 1'b1;
         end
      end
      if (dividend_neg != divisor_neg) q = -q;
      if (dividend_neg) r = -r;
      expected.quotient  = q;
      expected.remainder = r;
      return expected;
   endfunction

   always @(posedge clock) begin
      division_t expected;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            divisions_in_flight.push_back(divide_words(div_opcode_e'(req_opcode),
                                                       req_dividend, req_divisor));
         end
         if (rsp_valid && !rsp_stall) begin
            if (divisions_in_flight.size() == 0) begin
               report_mismatch($sformatf("result with no request waiting: q=%h r=%h dz=%b",
                                         rsp_quotient, rsp_remainder, rsp_divide_by_zero));
            end else begin
               expected = divisions_in_flight.pop_front();
               if (rsp_quotient !== expected.quotient)
                  report_mismatch($sformatf("quotient: expected %h, got %h",
                                            expected.quotient, rsp_quotient));
               if (rsp_remainder !== expected.remainder)
                  report_mismatch($sformatf("remainder: expected %h, got %h",
                                            expected.remainder, rsp_remainder));
               if (rsp_divide_by_zero !== expected.divide_by_zero)
                  report_mismatch($sformatf("divide_by_zero: expected %b, got %b",
                                            expected.divide_by_zero, rsp_divide_by_zero));
            end
         end
      end
   end

endmodule

// ===== test/tb_int64_divide_unit_top.sv =====
// Testbench top for the 64-bit divide unit: clock, reset, request and stall stimulus,
// and the final verdict. Depends on i64div_pkg, int64_divide_unit_checker.sv and the RTL.
module tb_int64_divide_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   import i64div_pkg::*;
   import i64div_tb_pkg::*;

   localparam word_type MostNegative = 64'h8000_0000_0000_0000;
   localparam word_type MostPositive = 64'h7fff_ffff_ffff_ffff;
   localparam word_type AllOnes      = 64'hffff_ffff_ffff_ffff;
   localparam int       RandomCount  = 500;
   localparam int       DrainCycles  = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [63:0] req_dividend;
   logic [63:0] req_divisor;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_quotient;
   logic [63:0] rsp_remainder;
   logic        rsp_divide_by_zero;
   logic        steady_stretch;
   int          mismatch_count;
   int          divisions_pending;

   int64_divide_unit_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   int64_divide_unit_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .mismatch_count     (mismatch_count),
      .divisions_pending  (divisions_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !steady_stretch && ($urandom_range(99) < 13);
      end
   end

   function automatic word_type random_operand();
      word_type value;
      value = {$urandom, $urandom};
      case ($urandom_range(7))
         0: value = word_type'($urandom_range(15));
         1: value = value >> $urandom_range(63);
         2: value = -word_type'($urandom_range(15));
         3: begin
            case ($urandom_range(4))
               0: value = '0;
               1: value = 64'd1;
               2: value = AllOnes;
               3: value = MostNegative;
               default: value = MostPositive;
            endcase
         end
         4: value = -(value >> $urandom_range(63));
         default: ;
      endcase
      return value;
   endfunction

   task automatic send_division(div_opcode_e op, word_type dividend, word_type divisor);
      while (!steady_stretch && $urandom_range(99) < 13) begin
         req_valid    <= 1'b0;
         req_opcode   <= 1'($urandom);
         req_dividend <= {$urandom, $urandom};
         req_divisor  <= {$urandom, $urandom};
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_dividend <= dividend;
      req_divisor  <= divisor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_opcode     = 1'b0;
      req_dividend   = '0;
      req_divisor    = '0;
      steady_stretch = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_division(OP_UNSIGNED, '0, 64'd1);
      send_division(OP_UNSIGNED, AllOnes, 64'd1);
      send_division(OP_UNSIGNED, AllOnes, AllOnes);
      send_division(OP_UNSIGNED, 64'd1, AllOnes);
      send_division(OP_UNSIGNED, MostNegative, 64'd3);
      send_division(OP_UNSIGNED, AllOnes, MostNegative);
      send_division(OP_UNSIGNED, 64'd12345, '0);
      send_division(OP_UNSIGNED, '0, '0);
      send_division(OP_SIGNED, MostNegative, AllOnes);
      send_division(OP_SIGNED, MostNegative, 64'd1);
      send_division(OP_SIGNED, MostNegative, MostNegative);
      send_division(OP_SIGNED, AllOnes, MostNegative);
      send_division(OP_SIGNED, MostPositive, AllOnes);
      send_division(OP_SIGNED, MostPositive, MostNegative);
      send_division(OP_SIGNED, -64'd7, 64'd2);
      send_division(OP_SIGNED, 64'd7, -64'd2);
      send_division(OP_SIGNED, -64'd7, -64'd2);
      send_division(OP_SIGNED, 64'd7, 64'd2);
      send_division(OP_SIGNED, MostNegative, '0);
      send_division(OP_SIGNED, AllOnes, '0);
      send_division(OP_SIGNED, '0, AllOnes);
      send_division(OP_SIGNED, 64'd100, 64'd7);

      for (int n = 0; n < RandomCount; n++) begin
         steady_stretch <= (n >= 200) && (n < 320);
         send_division($urandom_range(1) ? OP_SIGNED : OP_UNSIGNED,
                       random_operand(), random_operand());
      end
      req_valid      <= 1'b0;
      steady_stretch <= 1'b0;

      while (divisions_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/i64div_pkg.sv
sv/i64div_core.sv
sv/int64_divide_unit_top.sv
test/int64_divide_unit_checker.sv
test/tb_int64_divide_unit_top.sv
